### hw/rtl/resp_bulk_string_framer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the RESP bulk string framer
// ---------------------------------------------------------------------------
`ifndef RESP_BULK_STRING_FRAMER_ASSERT_SVH
`define RESP_BULK_STRING_FRAMER_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define RBSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rbsf assertion failed");

// Clocked property that is also checked across reset.
`define RBSF_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rbsf reset assertion failed");

`endif

### hw/rtl/rbsf_pkg.sv
// ---------------------------------------------------------------------------
// rbsf_pkg
// Types, constants and microcode for the RESP bulk string framer.
// ---------------------------------------------------------------------------
package rbsf_pkg;

  localparam int MAX_DIGITS_DEF = 9;
  localparam int LEN_W          = 30;
  localparam int BYTE_W         = 8;
  // wide enough for 9 * 10^9 and 10^10 - 1
  localparam int MUL_W          = 34;

  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [BYTE_W-1:0] CH_ONE    = 8'h31;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_CR     = 8'h0d;
  localparam logic [BYTE_W-1:0] CH_LF     = 8'h0a;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] upc_t;

  // microprogram addresses
  localparam upc_t UA_IDLE     = 4'd0;
  localparam upc_t UA_H_DOLLAR = 4'd1;
  localparam upc_t UA_H_DIGIT  = 4'd2;
  localparam upc_t UA_H_CR     = 4'd3;
  localparam upc_t UA_H_LF     = 4'd4;
  localparam upc_t UA_T_CR     = 4'd5;
  localparam upc_t UA_T_LF     = 4'd6;
  localparam upc_t UA_N_DOLLAR = 4'd7;
  localparam upc_t UA_N_MINUS  = 4'd8;
  localparam upc_t UA_N_ONE    = 4'd9;

  typedef enum logic [2:0] {
    SRC_NONE,
    SRC_DOLLAR,
    SRC_MINUS,
    SRC_ONE,
    SRC_CR,
    SRC_LF,
    SRC_DIGIT
  } src_t;

  typedef enum logic [1:0] {
    LST_NO,
    LST_YES,
    LST_OPEN
  } last_t;

  typedef enum logic [1:0] {
    JC_NEXT,
    JC_ALWAYS,
    JC_DIG_MORE,
    JC_OPEN
  } jc_t;

  typedef struct packed {
    logic  dispatch;
    src_t  src;
    last_t last;
    jc_t   jc;
    upc_t  tgt;
  } ucw_t;

  typedef struct packed {
    logic adv;
    logic dig_more;
    logic open;
    logic disp;
    upc_t disp_tgt;
  } ustat_t;

  function automatic ucw_t uword(logic dsp, src_t s, last_t l, jc_t j, upc_t t);
    ucw_t w;
    w.dispatch = dsp;
    w.src      = s;
    w.last     = l;
    w.jc       = j;
    w.tgt      = t;
    return w;
  endfunction

  // control store
  function automatic ucw_t ucode(upc_t a);
    ucw_t w;
    unique case (a)
      UA_IDLE:     w = uword(1'b1, SRC_NONE,   LST_NO,   JC_ALWAYS,   UA_IDLE);
      UA_H_DOLLAR: w = uword(1'b0, SRC_DOLLAR, LST_NO,   JC_NEXT,     UA_IDLE);
      UA_H_DIGIT:  w = uword(1'b0, SRC_DIGIT,  LST_NO,   JC_DIG_MORE, UA_H_DIGIT);
      UA_H_CR:     w = uword(1'b0, SRC_CR,     LST_NO,   JC_NEXT,     UA_IDLE);
      UA_H_LF:     w = uword(1'b0, SRC_LF,     LST_OPEN, JC_OPEN,     UA_IDLE);
      UA_T_CR:     w = uword(1'b0, SRC_CR,     LST_NO,   JC_NEXT,     UA_IDLE);
      UA_T_LF:     w = uword(1'b0, SRC_LF,     LST_YES,  JC_ALWAYS,   UA_IDLE);
      UA_N_DOLLAR: w = uword(1'b0, SRC_DOLLAR, LST_NO,   JC_NEXT,     UA_IDLE);
      UA_N_MINUS:  w = uword(1'b0, SRC_MINUS,  LST_NO,   JC_NEXT,     UA_IDLE);
      UA_N_ONE:    w = uword(1'b0, SRC_ONE,    LST_NO,   JC_ALWAYS,   UA_T_CR);
      default:     w = uword(1'b0, SRC_NONE,   LST_NO,   JC_ALWAYS,   UA_IDLE);
    endcase
    return w;
  endfunction

  // elaboration-time power of ten
  function automatic longint unsigned pow10(int n);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * 10;
    return r;
  endfunction

endpackage

### hw/rtl/rbsf_ifs.sv
// ---------------------------------------------------------------------------
// rbsf channel interfaces
// Valid/ready channels for header/data items in and framed bytes out.
// ---------------------------------------------------------------------------
interface rbsf_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [29:0] length;
  logic        is_null;
  logic [7:0]  data_byte;

  modport source (output valid, opcode, length, is_null, data_byte, input ready);
  modport sink   (input valid, opcode, length, is_null, data_byte, output ready);
endinterface

interface rbsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

### hw/rtl/rbsf_sequencer.sv
// ---------------------------------------------------------------------------
// rbsf_sequencer
// Step counter and control store; picks the next step from the datapath
// status (dispatch on an accepted item, conditional and plain jumps).
// ---------------------------------------------------------------------------
module rbsf_sequencer (
  input  logic            clk,
  input  logic            rst_n,
  input  rbsf_pkg::ustat_t st,
  output rbsf_pkg::ucw_t   cw
);
  import rbsf_pkg::*;

  upc_t pc_r;
  upc_t pc_nxt;

  assign cw = ucode(pc_r);

  always_comb begin
    pc_nxt = pc_r;
    if (cw.dispatch) begin
      if (st.disp) pc_nxt = st.disp_tgt;
    end else if (st.adv) begin
      unique case (cw.jc)
        JC_NEXT:     pc_nxt = pc_r + 1'b1;
        JC_ALWAYS:   pc_nxt = cw.tgt;
        JC_DIG_MORE: pc_nxt = st.dig_more ? cw.tgt : pc_r + 1'b1;
        JC_OPEN:     pc_nxt = st.open ? cw.tgt : pc_r + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) pc_r <= UA_IDLE;
    else        pc_r <= pc_nxt;
  end

endmodule

### hw/rtl/rbsf_datapath.sv
// ---------------------------------------------------------------------------
// rbsf_datapath
// Length/digit registers, one-digit-per-step decimal unit, frame counter
// and the output register, all steered by the current control word.
// ---------------------------------------------------------------------------
module rbsf_datapath #(
  parameter int MAX_DIGITS = rbsf_pkg::MAX_DIGITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  rbsf_pkg::ucw_t   cw,
  output rbsf_pkg::ustat_t st,
  rbsf_in_if.sink          in_ch,
  rbsf_out_if.source       out_ch
);
  import rbsf_pkg::*;

  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [MUL_W-1:0] LEN_LIM = MUL_W'(pow10(MAX_DIGITS) - 1);
  localparam logic [PW-1:0]    P_TOP   = PW'(MAX_DIGITS - 1);

  // k * 10^p for every digit position p and k = 1..9
  logic [MUL_W-1:0] mul_tbl [MAX_DIGITS][1:9];

  for (genvar gp = 0; gp < MAX_DIGITS; gp++) begin : g_pos
    for (genvar gk = 1; gk <= 9; gk++) begin : g_k
      assign mul_tbl[gp][gk] = MUL_W'(pow10(gp) * gk);
    end
  end

  logic [LEN_W-1:0]  v_r, v_nxt;
  logic [PW-1:0]     p_r, p_nxt;
  logic              started_r, started_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic              open_r, open_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              slot_free;
  logic              in_fire;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              emit_last;
  logic [LEN_W-1:0]  len_sat;
  logic [3:0]        dig;
  logic [MUL_W-1:0]  dig_sub;
  logic              data_ok;

  assign slot_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = cw.dispatch && slot_free;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign data_ok      = open_r && (rem_r != '0);

  assign len_sat = ({{(MUL_W-LEN_W){1'b0}}, in_ch.length} > LEN_LIM) ?
                   LEN_LIM[LEN_W-1:0] : in_ch.length;

  // digit = number of multiples of 10^p not above v
  always_comb begin
    dig     = '0;
    dig_sub = '0;
    for (int k = 1; k <= 9; k++) begin
      if ({{(MUL_W-LEN_W){1'b0}}, v_r} >= mul_tbl[p_r][k]) begin
        dig     = 4'(k);
        dig_sub = mul_tbl[p_r][k];
      end
    end
  end

  always_comb begin
    emit      = 1'b0;
    emit_byte = CH_CR;
    emit_last = 1'b0;
    if (cw.dispatch) begin
      emit      = in_fire && (in_ch.opcode == OP_DATA) && data_ok;
      emit_byte = in_ch.data_byte;
      emit_last = (rem_r != LEN_W'(1));
    end else begin
      unique case (cw.src)
        SRC_NONE:   emit = 1'b0;
        SRC_DOLLAR: begin emit = 1'b1; emit_byte = CH_DOLLAR; end
        SRC_MINUS:  begin emit = 1'b1; emit_byte = CH_MINUS;  end
        SRC_ONE:    begin emit = 1'b1; emit_byte = CH_ONE;    end
        SRC_CR:     begin emit = 1'b1; emit_byte = CH_CR;     end
        SRC_LF:     begin emit = 1'b1; emit_byte = CH_LF;     end
        SRC_DIGIT: begin
          // leading zeros are skipped, the units digit always goes out
          emit      = (dig != '0) || started_r || (p_r == '0);
          emit_byte = CH_ZERO + BYTE_W'(dig);
        end
        default:    emit = 1'b0;
      endcase
      unique case (cw.last)
        LST_NO:   emit_last = 1'b0;
        LST_YES:  emit_last = 1'b1;
        LST_OPEN: emit_last = open_r;
        default:  emit_last = 1'b0;
      endcase
    end
  end

  always_comb begin
    st.adv      = !emit || slot_free;
    st.dig_more = (p_r != '0);
    st.open     = open_r;
    st.disp     = 1'b0;
    st.disp_tgt = UA_IDLE;
    if (in_fire) begin
      if (in_ch.opcode == OP_HEADER) begin
        st.disp     = 1'b1;
        st.disp_tgt = in_ch.is_null ? UA_N_DOLLAR : UA_H_DOLLAR;
      end else if (data_ok && rem_r == LEN_W'(1)) begin
        st.disp     = 1'b1;
        st.disp_tgt = UA_T_CR;
      end
    end
  end

  always_comb begin
    v_nxt         = v_r;
    p_nxt         = p_r;
    started_nxt   = started_r;
    rem_nxt       = rem_r;
    open_nxt      = open_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (cw.dispatch) begin
      if (in_fire) begin
        if (in_ch.opcode == OP_HEADER) begin
          v_nxt       = len_sat;
          p_nxt       = P_TOP;
          started_nxt = 1'b0;
          rem_nxt     = in_ch.is_null ? '0 : len_sat;
          open_nxt    = !in_ch.is_null && (len_sat != '0);
        end else if (data_ok) begin
          rem_nxt  = rem_r - 1'b1;
          open_nxt = (rem_r != LEN_W'(1));
        end else begin
          open_nxt = 1'b0;
        end
      end
    end else if (cw.src == SRC_DIGIT && st.adv) begin
      v_nxt = v_r - dig_sub[LEN_W-1:0];
      if (emit) started_nxt = 1'b1;
      if (p_r != '0) p_nxt = p_r - 1'b1;
    end

    if (emit && slot_free) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      p_r         <= '0;
    end else begin
      rem_r       <= rem_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      p_r         <= p_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.run_last = out_last_r;

endmodule

### hw/rtl/resp_bulk_string_framer.sv
// ---------------------------------------------------------------------------
// resp_bulk_string_framer
// Frames bulk strings into the RESP2 byte stream.
// ---------------------------------------------------------------------------
// Input channel in_ch carries header items (opcode 0: length, is_null) and
// payload items (opcode 1: data_byte). Output channel out_ch carries one
// framed byte per item; run_last marks the last byte caused by an input item.
// Both channels use valid/ready, an item moves when both are high.
// A payload item is taken and its byte registered in the same cycle, so
// payload flows at one byte per cycle while the receiver does not stall;
// the final payload byte is followed by the CR LF trailer, during which
// no input is taken. A header is taken, then runs a short microprogram: '$',
// one step per decimal position (MAX_DIGITS positions, leading zeros skipped
// but still spent), CR, LF, plus CR LF for a zero length; a null header runs
// '$', '-', '1', CR, LF. Taking a header moves the sequencer to the '$'
// step, whose byte is then loaded into the output register. Output sits in a
// single register: while the receiver stalls, the sequencer holds on each
// step that emits a byte and in_ch.ready stays low. Reset clears the frame
// state and the output valid bit; no frame is open afterwards.
// ---------------------------------------------------------------------------
module resp_bulk_string_framer #(
  parameter int MAX_DIGITS = rbsf_pkg::MAX_DIGITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rbsf_in_if.sink    in_ch,
  rbsf_out_if.source out_ch
);
  import rbsf_pkg::*;

  ucw_t   cw;
  ustat_t st;

  rbsf_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw)
  );

  rbsf_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cw     (cw),
    .st     (st),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

### hw/rtl/rbsf_checker.sv
// ---------------------------------------------------------------------------
// rbsf_port_checker
// Port-level checks for the framer, attached to the top level by bind.
// ---------------------------------------------------------------------------
`include "resp_bulk_string_framer_assert.svh"

module rbsf_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_opcode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_run_last
);
  import rbsf_pkg::*;

  logic       hdr_acc;
  logic       out_stall;
  logic [8:0] out_word;
  logic       dollar_out;

  assign hdr_acc    = in_valid && in_ready && (in_opcode == OP_HEADER);
  assign out_stall  = out_valid && !out_ready;
  assign out_word   = {out_byte, out_run_last};
  assign dollar_out = out_valid && (out_byte == CH_DOLLAR);

  // a stalled output holds its item
  `RBSF_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_valid && $stable(out_word))

  // no input is taken while the output register is blocked
  `RBSF_ASSERT(a_no_in_on_stall, clk, rst_n, out_stall |-> !in_ready)

  // every accepted header is followed by an output gap and then '$'
  `RBSF_ASSERT(a_hdr_dollar, clk, rst_n, hdr_acc |=> !out_valid ##1 dollar_out)

  `RBSF_ASSERT_RST(a_rst_empty, clk, !rst_n |=> !out_valid)

endmodule

bind resp_bulk_string_framer rbsf_port_checker u_rbsf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_opcode    (in_ch.opcode),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_byte     (out_ch.out_byte),
  .out_run_last (out_ch.run_last)
);

### sim/rbsf_checker.sv
// ---------------------------------------------------------------------------
// rbsf_checker
// Watches both channels of the RESP bulk string framer, predicts the framed
// byte stream for every accepted item and compares it byte by byte.
// ---------------------------------------------------------------------------
module rbsf_checker
  import rbsf_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rbsf_in_if          in_ch,
  rbsf_out_if         out_ch,
  output int unsigned fail_count,
  output int unsigned n_pending
);

  typedef struct packed {
    logic [7:0] byte_v;
    logic       run_last;
  } wire_byte_t;

  wire_byte_t  wire_q[$];
  logic        frame_open;
  logic [29:0] bytes_left;

  initial begin
    fail_count = 0;
    n_pending  = 0;
    frame_open = 1'b0;
    bytes_left = '0;
  end

  // Expected wire bytes for one accepted item, appended to wire_q.
  task automatic predict_wire_bytes(input logic op, input logic [29:0] len,
                                    input logic nul, input logic [7:0] db);
    wire_byte_t      run[$];
    logic [7:0]      digs[10];
    longint unsigned n;
    longint unsigned lim;
    int              nd;
    run = {};
    if (op == OP_HEADER) begin
      frame_open = 1'b0;
      bytes_left = '0;
      if (nul) begin
        run.push_back({CH_DOLLAR, 1'b0});
        run.push_back({CH_MINUS, 1'b0});
        run.push_back({CH_ONE, 1'b0});
        run.push_back({CH_CR, 1'b0});
        run.push_back({CH_LF, 1'b0});
      end else begin
        lim = 1;
        for (int i = 0; i < MAX_DIGITS; i++) lim = lim * 10;
        lim = lim - 1;
        n = (len > lim) ? lim : len;
        if (n != 0) begin
          bytes_left = n[29:0];
          frame_open = 1'b1;
        end
        nd = 0;
        do begin
          digs[nd] = CH_ZERO + 8'(n % 10);
          n = n / 10;
          nd++;
        end while (n != 0);
        run.push_back({CH_DOLLAR, 1'b0});
        for (int i = nd - 1; i >= 0; i--) run.push_back({digs[i], 1'b0});
        run.push_back({CH_CR, 1'b0});
        run.push_back({CH_LF, 1'b0});
        if (!frame_open) begin
          run.push_back({CH_CR, 1'b0});
          run.push_back({CH_LF, 1'b0});
        end
      end
    end else if (!frame_open || bytes_left == 0) begin
      // stray payload byte: dropped
      frame_open = 1'b0;
    end else begin
      run.push_back({db, 1'b0});
      bytes_left = bytes_left - 1;
      if (bytes_left == 0) begin
        run.push_back({CH_CR, 1'b0});
        run.push_back({CH_LF, 1'b0});
        frame_open = 1'b0;
      end
    end
    if (run.size() > 0) run[run.size() - 1].run_last = 1'b1;
    foreach (run[i]) wire_q.push_back(run[i]);
  endtask

  always @(posedge clk) begin : watch
    wire_byte_t want;
    if (!rst_n) begin
      wire_q.delete();
      frame_open = 1'b0;
      bytes_left = '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_wire_bytes(in_ch.opcode, in_ch.length, in_ch.is_null, in_ch.data_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (wire_q.size() == 0) begin
          $error("unexpected output byte %h run_last %b", out_ch.out_byte, out_ch.run_last);
          fail_count++;
        end else begin
          want = wire_q.pop_front();
          if (out_ch.out_byte !== want.byte_v) begin
            $error("out_byte: expected %h, got %h", want.byte_v, out_ch.out_byte);
            fail_count++;
          end
          if (out_ch.run_last !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, out_ch.run_last);
            fail_count++;
          end
        end
      end
    end
    n_pending = wire_q.size();
  end

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RESP bulk string framer: directed frames for
// the corner cases, then random well-formed, null, abandoned and stray-byte
// traffic with bursty sending and a stalling receiver.
// ---------------------------------------------------------------------------
module tb;
  import rbsf_pkg::*;

  localparam int RAND_ITEMS = 350;
  localparam int LIMIT      = 300000;
  localparam int DRAIN      = 40;

  logic clk;
  logic rst_n;

  rbsf_in_if  in_ch();
  rbsf_out_if out_ch();

  int unsigned fail_count;
  int unsigned n_pending;

  resp_bulk_string_framer u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rbsf_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .fail_count(fail_count),
    .n_pending (n_pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // receiver: new random stall mask per window, some windows never stall
  logic        rx_ready = 1'b0;
  logic [15:0] stall_mask = 16'hFFFF;
  logic [31:0] stall_cyc = '0;
  assign out_ch.ready = rx_ready;

  always @(negedge clk) begin
    if (stall_cyc[4:0] == 5'd0) begin
      if ($urandom_range(0, 3) == 0) stall_mask <= 16'hFFFF;
      else stall_mask <= 16'($urandom) | 16'h0101;
    end
    rx_ready  <= stall_mask[stall_cyc[3:0]];
    stall_cyc <= stall_cyc + 1;
  end

  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("** resp_bulk_string_framer: FAILED **");
      $finish;
    end
  end

  int   burst_left = 0;
  bit   steady = 1'b0;
  int   items_sent = 0;

  task automatic send_item(input logic op, input logic [29:0] len,
                           input logic nul, input logic [7:0] db);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if (!steady) begin
        gap = $urandom_range(1, 6);
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.length    <= len;
    in_ch.is_null   <= nul;
    in_ch.data_byte <= db;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_data(input logic [7:0] db);
    send_item(OP_DATA, 30'($urandom), 1'($urandom), db);
  endtask

  task automatic send_frame(input logic [29:0] len);
    send_item(OP_HEADER, len, 1'b0, 8'($urandom));
    repeat (len) send_data(8'($urandom));
  endtask

  initial begin
    int          kind;
    logic [29:0] len;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_HEADER;
    in_ch.length    = '0;
    in_ch.is_null   = 1'b0;
    in_ch.data_byte = '0;
    rst_n           = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed corners
    send_item(OP_DATA, '1, 1'b1, 8'hFF);            // no frame open: dropped
    send_item(OP_HEADER, '1, 1'b1, 8'hFF);          // null, length ignored
    send_item(OP_HEADER, '0, 1'b0, 8'h00);          // zero length
    send_item(OP_HEADER, 30'd1, 1'b0, 8'h00);
    send_item(OP_DATA, '1, 1'b1, 8'h00);
    send_item(OP_HEADER, 30'd3, 1'b0, 8'h00);
    send_item(OP_DATA, '0, 1'b0, 8'hFF);
    send_item(OP_DATA, '0, 1'b0, 8'h5A);
    send_item(OP_DATA, '0, 1'b0, 8'hA5);
    send_item(OP_DATA, '0, 1'b0, 8'h77);            // after trailer: dropped
    send_item(OP_HEADER, 30'd999999999, 1'b0, 8'h00);
    send_item(OP_DATA, '0, 1'b0, 8'h11);
    send_item(OP_HEADER, 30'd1000000000, 1'b0, 8'h00); // abandons, saturates
    send_item(OP_DATA, '0, 1'b0, 8'h22);
    send_item(OP_HEADER, '1, 1'b0, 8'h00);
    send_item(OP_HEADER, 30'd536870912, 1'b0, 8'h00);
    send_item(OP_HEADER, '0, 1'b1, 8'h00);          // null header closes frame
    send_item(OP_DATA, '0, 1'b0, 8'h33);            // dropped
    send_item(OP_HEADER, 30'd10, 1'b0, 8'h00);
    send_item(OP_DATA, '0, 1'b0, 8'h01);
    send_item(OP_DATA, '0, 1'b0, 8'h80);
    send_frame(30'd2);                              // abandons the 10-byte frame
    send_frame(30'd100);

    while (items_sent < RAND_ITEMS) begin
      if ($urandom_range(0, 7) == 0) steady = ($urandom_range(0, 2) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        if ($urandom_range(0, 4) == 0) len = 30'($urandom_range(13, 40));
        else len = 30'($urandom_range(0, 12));
        send_frame(len);
      end else if (kind < 75) begin
        send_item(OP_HEADER, 30'($urandom), 1'b1, 8'($urandom));
      end else if (kind < 90) begin
        // header with a wide-ranging length, usually cut short by the next header
        len = 30'($urandom) >> $urandom_range(0, 29);
        send_item(OP_HEADER, len, 1'b0, 8'($urandom));
        repeat ($urandom_range(0, 4)) send_data(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3)) send_data(8'($urandom));
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (n_pending == 0);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) $display("** resp_bulk_string_framer: PASSED **");
    else $display("** resp_bulk_string_framer: FAILED **");
    $finish;
  end

endmodule
